### src/hpi_pkg.sv
// ----------------------------------------------------------------------------
// hpi_pkg
// Shared types and constants for the half-pel motion compensation interpolator.
// ----------------------------------------------------------------------------
package hpi_pkg;

    localparam int ROW_BYTES_DEF = 8;
    localparam int PIX_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 2;

    typedef enum logic [1:0] {
        MODE_COPY = 2'd0,
        MODE_HORZ = 2'd1,
        MODE_VERT = 2'd2,
        MODE_DIAG = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERP_MODE  = 2'd0,
        CFG_NO_ROUND     = 2'd1,
        CFG_AVERAGE_DEST = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_mode mode;
        logic  no_round;
        logic  avg_dest;
    } t_ctrl;

endpackage

### src/hpi_lane.sv
// ----------------------------------------------------------------------------
// hpi_lane
// One pixel lane: copy, two-tap or four-tap half-pel average, then an
// optional average with the destination pixel.
// ----------------------------------------------------------------------------
module hpi_lane (
    input  hpi_pkg::t_ctrl                i_ctrl,
    input  logic [hpi_pkg::PIX_W-1:0]     i_cur,
    input  logic [hpi_pkg::PIX_W-1:0]     i_cur_right,
    input  logic [hpi_pkg::PIX_W-1:0]     i_prev,
    input  logic [hpi_pkg::PIX_W-1:0]     i_prev_right,
    input  logic [hpi_pkg::PIX_W-1:0]     i_dest,
    output logic [hpi_pkg::PIX_W-1:0]     o_pix
);

    localparam int PW = hpi_pkg::PIX_W;

    logic          rnd;
    logic [PW:0]   sum_h;
    logic [PW:0]   sum_v;
    logic [PW+1:0] sum_d;
    logic [PW-1:0] pred;
    logic [PW:0]   sum_dst;

    assign rnd = ~i_ctrl.no_round;

    assign sum_h = {1'b0, i_cur} + {1'b0, i_cur_right} + {{PW{1'b0}}, rnd};
    assign sum_v = {1'b0, i_prev} + {1'b0, i_cur} + {{PW{1'b0}}, rnd};
    // four-tap rounding adds 2, truncating form adds 1
    assign sum_d = {2'b00, i_prev} + {2'b00, i_prev_right} + {2'b00, i_cur}
                 + {2'b00, i_cur_right} + {{PW{1'b0}}, rnd, ~rnd};

    always_comb begin
        case (i_ctrl.mode)
            hpi_pkg::MODE_COPY: pred = i_cur;
            hpi_pkg::MODE_HORZ: pred = sum_h[PW:1];
            hpi_pkg::MODE_VERT: pred = sum_v[PW:1];
            hpi_pkg::MODE_DIAG: pred = sum_d[PW+1:2];
            default:            pred = i_cur;
        endcase
    end

    assign sum_dst = {1'b0, pred} + {1'b0, i_dest} + {{PW{1'b0}}, rnd};
    assign o_pix   = i_ctrl.avg_dest ? sum_dst[PW:1] : pred;

endmodule

### src/hpi_row.sv
// ----------------------------------------------------------------------------
// hpi_row
// Row datapath: one lane per pixel, right neighbors taken from the row and
// its extra byte.
// ----------------------------------------------------------------------------
module hpi_row #(
    parameter int ROW_BYTES = hpi_pkg::ROW_BYTES_DEF
) (
    input  hpi_pkg::t_ctrl                            i_ctrl,
    input  logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]       i_row,
    input  logic [hpi_pkg::PIX_W-1:0]                 i_extra,
    input  logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]       i_prev_row,
    input  logic [hpi_pkg::PIX_W-1:0]                 i_prev_extra,
    input  logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]       i_dest,
    output logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]       o_pred
);

    localparam int PW    = hpi_pkg::PIX_W;
    localparam int ROW_W = ROW_BYTES * PW;

    logic [ROW_W+PW-1:0] cur_ext;
    logic [ROW_W+PW-1:0] prev_ext;

    assign cur_ext  = {i_extra, i_row};
    assign prev_ext = {i_prev_extra, i_prev_row};

    for (genvar g = 0; g < ROW_BYTES; g++) begin : g_lane
        hpi_lane u_lane (
            .i_ctrl       (i_ctrl),
            .i_cur        (cur_ext[g*PW +: PW]),
            .i_cur_right  (cur_ext[(g+1)*PW +: PW]),
            .i_prev       (prev_ext[g*PW +: PW]),
            .i_prev_right (prev_ext[(g+1)*PW +: PW]),
            .i_dest       (i_dest[g*PW +: PW]),
            .o_pix        (o_pred[g*PW +: PW])
        );
    end

endmodule

### src/half_pel_motion_comp_interp.sv
// ----------------------------------------------------------------------------
// half_pel_motion_comp_interp
// Half-pel motion compensation interpolator, one row of pixels per word.
//
// Input channel i_valid / o_stall carries one reference row, its extra byte,
// the destination row and the priming / last flags. Output channel
// o_valid / i_stall returns the predicted row and the last flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 mode, 1 no_round, 2 average_into_dest); write only while idle.
// Path: an accepted word goes through the input register, the lane logic and
// the result register, where it waits until it is taken.
// Throughput: one word per cycle while i_stall is low, set by the single row datapath.
// A priming row in vertical or diagonal mode only loads the previous-row
// register and produces no output word.
// When i_stall holds the output, one word waits in the result register and
// one in the input register; o_stall rises once both are full.
// Reset clears both stages, the configuration and the previous row.
// ----------------------------------------------------------------------------
module half_pel_motion_comp_interp #(
    parameter int ROW_BYTES = hpi_pkg::ROW_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [hpi_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [hpi_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]   i_row_pixels,
    input  logic [hpi_pkg::PIX_W-1:0]             i_extra_pixel,
    input  logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]   i_dest_pixels,
    input  logic                                  i_priming_row,
    input  logic                                  i_last_row,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ROW_BYTES*hpi_pkg::PIX_W-1:0]   o_pred_row,
    output logic                                  o_row_is_last
);

    localparam int PW    = hpi_pkg::PIX_W;
    localparam int ROW_W = ROW_BYTES * PW;

    hpi_pkg::t_ctrl r_ctrl;

    logic [ROW_W-1:0] r_prev_row;
    logic [PW-1:0]    r_prev_extra;

    logic             r_s1_valid;
    logic [ROW_W-1:0] r_s1_row;
    logic [PW-1:0]    r_s1_extra;
    logic [ROW_W-1:0] r_s1_prev_row;
    logic [PW-1:0]    r_s1_prev_extra;
    logic [ROW_W-1:0] r_s1_dest;
    logic             r_s1_priming;
    logic             r_s1_last;

    logic             r_o_valid;
    logic [ROW_W-1:0] r_o_pred;
    logic             r_o_last;

    logic             in_acc;
    logic             s1_has_res;
    logic             s2_free;
    logic             s1_adv;
    logic [ROW_W-1:0] pred;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.mode     <= hpi_pkg::MODE_COPY;
            r_ctrl.no_round <= 1'b0;
            r_ctrl.avg_dest <= 1'b0;
        end else if (i_cfg_we) begin
            case (hpi_pkg::t_cfg_idx'(i_cfg_idx))
                hpi_pkg::CFG_INTERP_MODE:  r_ctrl.mode     <= hpi_pkg::t_mode'(i_cfg_data);
                hpi_pkg::CFG_NO_ROUND:     r_ctrl.no_round <= i_cfg_data[0];
                hpi_pkg::CFG_AVERAGE_DEST: r_ctrl.avg_dest <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // flow control
    assign s1_has_res = r_s1_valid && !(r_ctrl.mode[1] && r_s1_priming);
    assign s2_free    = !r_o_valid || !i_stall;
    assign s1_adv     = !r_s1_valid || !s1_has_res || s2_free;
    assign o_stall    = !s1_adv;
    assign in_acc     = i_valid && s1_adv;

    // previous reference row, loaded by every word in arrival order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_row   <= '0;
            r_prev_extra <= '0;
        end else if (in_acc) begin
            r_prev_row   <= i_row_pixels;
            r_prev_extra <= i_extra_pixel;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row        <= i_row_pixels;
            r_s1_extra      <= i_extra_pixel;
            r_s1_prev_row   <= r_prev_row;
            r_s1_prev_extra <= r_prev_extra;
            r_s1_dest       <= i_dest_pixels;
            r_s1_priming    <= i_priming_row;
            r_s1_last       <= i_last_row;
        end
    end

    hpi_row #(
        .ROW_BYTES (ROW_BYTES)
    ) u_row (
        .i_ctrl       (r_ctrl),
        .i_row        (r_s1_row),
        .i_extra      (r_s1_extra),
        .i_prev_row   (r_s1_prev_row),
        .i_prev_extra (r_s1_prev_extra),
        .i_dest       (r_s1_dest),
        .o_pred       (pred)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_free) begin
            r_o_valid <= s1_has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && s1_has_res) begin
            r_o_pred <= pred;
            r_o_last <= r_s1_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pred_row    = r_o_pred;
    assign o_row_is_last = r_o_last;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_o_valid && i_stall))
        else $error("input stalled while a stage is free");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word not held in input register");

    a_prev_row_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_prev_row == $past(i_row_pixels)))
        else $error("previous row not loaded from accepted word");

    a_priming_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_ctrl.mode[1] && r_s1_priming && !r_o_valid) |=> !r_o_valid)
        else $error("priming row produced a result");
`endif

endmodule
